// ----- design/divrt_pkg.sv -----
`timescale 1ns / 1ps

package divrt_pkg;

   localparam int TICKS_W        = 6;
   localparam int VALUE_W        = 8;
   localparam int CONTROL_W      = 3;
   localparam int DIV_PRESCALE_W = 10;
   localparam int CNT_PRESCALE_W = 16;
   localparam int PERIOD_W       = 11;
   localparam int CSR_ADDR_W     = 1;
   localparam int CSR_DATA_W     = 8;

   // register map
   localparam logic [CSR_ADDR_W-1:0] CSR_RELOAD  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CONTROL = 1'b1;

   // timer_control fields
   localparam int CTRL_ENABLE_BIT = 2;

   localparam logic [1:0] RATE_1024 = 2'd0;
   localparam logic [1:0] RATE_16   = 2'd1;
   localparam logic [1:0] RATE_64   = 2'd2;
   localparam logic [1:0] RATE_256  = 2'd3;

   localparam logic [VALUE_W-1:0] COUNTER_TOP = 8'hFF;

   typedef struct packed {
      logic [TICKS_W-1:0] elapsed_ticks;
      logic               clear_divider;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] divider_value;
      logic [VALUE_W-1:0] counter_value;
      logic               overflow_irq;
   } rsp_type;

   function automatic logic [PERIOD_W-1:0] counter_period(input logic [1:0] rate);
      logic [PERIOD_W-1:0] period;
      unique case (rate)
         RATE_1024: period = 11'd1024;
         RATE_16:   period = 11'd16;
         RATE_64:   period = 11'd64;
         RATE_256:  period = 11'd256;
         default:   period = 11'd1024;
      endcase
      return period;
   endfunction

endpackage

// ----- design/divrt_accum.sv -----
`timescale 1ns / 1ps

// Add the item's ticks to a prescaler, take one period off when it is
// reached, and saturate at the prescaler's all-ones top value.
module divrt_accum #(
   parameter int ACC_W = 10
) (
   input  logic [ACC_W-1:0]              acc,
   input  logic [divrt_pkg::TICKS_W-1:0]  ticks,
   input  logic [divrt_pkg::PERIOD_W-1:0] period,
   output logic [ACC_W-1:0]              acc_next,
   output logic                          advance
);
   import divrt_pkg::*;

   localparam int SUM_W = ACC_W + 1;

   logic [SUM_W-1:0] sum;
   logic [SUM_W-1:0] period_ext;
   logic [SUM_W-1:0] rest;

   assign sum        = {1'b0, acc} + SUM_W'(ticks);
   assign period_ext = SUM_W'(period);
   assign advance    = (sum >= period_ext);
   assign rest       = advance ? (sum - period_ext) : sum;

   // clamp to the top value when the carry bit is set
   assign acc_next = rest[ACC_W] ? {ACC_W{1'b1}} : rest[ACC_W-1:0];

endmodule

// ----- design/divider_and_reloading_timer_top.sv -----
`timescale 1ns / 1ps

// Pipeline: a beat taken into the input register moves on into the result register
//   when the result register is empty or being drained; a stalled result holds it.
// Throughput: one beat per cycle while the result is not stalled; the divider/counter
//   state update is a single add, compare and subtract per prescaler.
// Reset (synchronous, active high): divider, counter, both prescalers, both
//   registers and all valid flags clear to zero.
module divider_and_reloading_timer_top #(
   parameter int DIVIDER_PERIOD = 512
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  divrt_pkg::req_type                  req_data,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output divrt_pkg::rsp_type                  rsp_data,

   input  logic                                csr_wr_en,
   input  logic [divrt_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [divrt_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import divrt_pkg::*;

   localparam logic [PERIOD_W-1:0] DivPeriod = PERIOD_W'(DIVIDER_PERIOD);

   // Configuration registers
   logic [VALUE_W-1:0]   reload_ff;
   logic [CONTROL_W-1:0] control_ff;

   // Timer state
   logic [VALUE_W-1:0]        divider_ff,       divider_in;
   logic [DIV_PRESCALE_W-1:0] div_prescale_ff,  div_prescale_in;
   logic [VALUE_W-1:0]        counter_ff,       counter_in;
   logic [CNT_PRESCALE_W-1:0] cnt_prescale_ff,  cnt_prescale_in;

   // Input stage and result stage
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic req_accept;
   logic s1_move;

   // Datapath intermediates
   logic [VALUE_W-1:0]        divider_base;
   logic [DIV_PRESCALE_W-1:0] div_prescale_base;
   logic [DIV_PRESCALE_W-1:0] div_prescale_sum;
   logic                      div_advance;
   logic [CNT_PRESCALE_W-1:0] cnt_prescale_sum;
   logic                      cnt_advance;
   logic                      cnt_enable;
   logic                      irq;

   // ------------------------------------------------------------------
   // Handshake: the input stage moves forward whenever the result
   // register is empty or being drained this cycle. A new beat enters
   // whenever the input stage is empty or moving on; a stalled result
   // holds the input stage, which then stalls the input.
   // ------------------------------------------------------------------
   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_move;
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !s1_move);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && rsp_stall);

   // ------------------------------------------------------------------
   // Divider: a clear request zeroes the divider and its prescaler
   // before this beat's ticks are counted.
   // ------------------------------------------------------------------
   assign divider_base      = s1_data_ff.clear_divider ? '0 : divider_ff;
   assign div_prescale_base = s1_data_ff.clear_divider ? '0 : div_prescale_ff;

   divrt_accum #(
      .ACC_W (DIV_PRESCALE_W)
   ) u_div_accum (
      .acc      (div_prescale_base),
      .ticks    (s1_data_ff.elapsed_ticks),
      .period   (DivPeriod),
      .acc_next (div_prescale_sum),
      .advance  (div_advance)
   );

   // ------------------------------------------------------------------
   // Counter: runs only while enabled; on overflow past the top value
   // reload from the reload register and raise the interrupt.
   // ------------------------------------------------------------------
   assign cnt_enable = control_ff[CTRL_ENABLE_BIT];

   divrt_accum #(
      .ACC_W (CNT_PRESCALE_W)
   ) u_cnt_accum (
      .acc      (cnt_prescale_ff),
      .ticks    (s1_data_ff.elapsed_ticks),
      .period   (counter_period(control_ff[1:0])),
      .acc_next (cnt_prescale_sum),
      .advance  (cnt_advance)
   );

   always_comb begin
      divider_in      = divider_ff;
      div_prescale_in = div_prescale_ff;
      counter_in      = counter_ff;
      cnt_prescale_in = cnt_prescale_ff;
      irq             = 1'b0;

      if (s1_move) begin
         div_prescale_in = div_prescale_sum;
         divider_in      = div_advance ? divider_base + 8'd1 : divider_base;

         if (cnt_enable) begin
            cnt_prescale_in = cnt_prescale_sum;
            if (cnt_advance) begin
               if (counter_ff == COUNTER_TOP) begin
                  counter_in = reload_ff;
                  irq        = 1'b1;
               end else begin
                  counter_in = counter_ff + 8'd1;
               end
            end
         end
      end
   end

   // Hold the result while stalled; load the fresh one when the stage moves.
   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (s1_move) begin
         rsp_data_in.divider_value = divider_in;
         rsp_data_in.counter_value = counter_in;
         rsp_data_in.overflow_irq  = irq;
      end
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff       <= '0;
         control_ff      <= '0;
         divider_ff      <= '0;
         div_prescale_ff <= '0;
         counter_ff      <= '0;
         cnt_prescale_ff <= '0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_addr)
               CSR_RELOAD:  reload_ff  <= csr_wdata[VALUE_W-1:0];
               CSR_CONTROL: control_ff <= csr_wdata[CONTROL_W-1:0];
               default: ;
            endcase
         end
         divider_ff      <= divider_in;
         div_prescale_ff <= div_prescale_in;
         counter_ff      <= counter_in;
         cnt_prescale_ff <= cnt_prescale_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers: no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_data_ff <= req_data;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- dv/timer_result_checker.sv -----
`timescale 1ns / 1ps

module timer_result_checker #(
   parameter int DIVIDER_PERIOD = 512
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   input  logic                                req_stall,
   input  divrt_pkg::req_type                  req_data,

   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  divrt_pkg::rsp_type                  rsp_data,

   input  logic                                csr_wr_en,
   input  logic [divrt_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [divrt_pkg::CSR_DATA_W-1:0]    csr_wdata,

   output int                                  pending,
   output int                                  mismatches,
   output int                                  overflows,
   output int                                  divider_wraps
);

   import divrt_pkg::*;

   localparam int unsigned DIV_PRESCALE_TOP = (1 << DIV_PRESCALE_W) - 1;
   localparam int unsigned CNT_PRESCALE_TOP = (1 << CNT_PRESCALE_W) - 1;

   // shadow of the timer registers and state
   logic [VALUE_W-1:0]        reload_q;
   logic [CONTROL_W-1:0]      control_q;
   logic [VALUE_W-1:0]        divider_q;
   logic [VALUE_W-1:0]        counter_q;
   logic [DIV_PRESCALE_W-1:0] div_prescale_q;
   logic [CNT_PRESCALE_W-1:0] cnt_prescale_q;

   rsp_type expected_readings[$];

   int beats_in    = 0;
   int beats_out   = 0;
   int error_tally = 0;
   int irq_tally   = 0;
   int wrap_tally  = 0;

   assign pending       = beats_in - beats_out;
   assign mismatches    = error_tally;
   assign overflows     = irq_tally;
   assign divider_wraps = wrap_tally;

   // apply one beat of elapsed ticks to the shadow state, return the reading
   function automatic rsp_type advance_timer(input req_type beat);
      int unsigned sum;
      int unsigned period;
      rsp_type     reading;
      reading.overflow_irq = 1'b0;
      if (beat.clear_divider) begin
         divider_q      = '0;
         div_prescale_q = '0;
      end
      sum = div_prescale_q + beat.elapsed_ticks;
      if (sum >= DIVIDER_PERIOD) begin
         sum = sum - DIVIDER_PERIOD;
         if (divider_q == '1) wrap_tally++;
         divider_q = divider_q + 1'b1;
      end
      if (sum > DIV_PRESCALE_TOP) sum = DIV_PRESCALE_TOP;
      div_prescale_q = sum[DIV_PRESCALE_W-1:0];

      if (control_q[CTRL_ENABLE_BIT]) begin
         case (control_q[1:0])
            RATE_16:  period = 16;
            RATE_64:  period = 64;
            RATE_256: period = 256;
            default:  period = 1024;
         endcase
         sum = cnt_prescale_q + beat.elapsed_ticks;
         if (sum >= period) begin
            sum = sum - period;
            if (counter_q == COUNTER_TOP) begin
               counter_q            = reload_q;
               reading.overflow_irq = 1'b1;
               irq_tally++;
            end else begin
               counter_q = counter_q + 1'b1;
            end
         end
         if (sum > CNT_PRESCALE_TOP) sum = CNT_PRESCALE_TOP;
         cnt_prescale_q = sum[CNT_PRESCALE_W-1:0];
      end
      reading.divider_value = divider_q;
      reading.counter_value = counter_q;
      return reading;
   endfunction

   task automatic report(input string why, input rsp_type want, input rsp_type got);
      error_tally++;
      if (error_tally <= 10) begin
         $display("%0t mismatch (%s): expected div=%0d cnt=%0d irq=%0b,",
                  $time, why, want.divider_value, want.counter_value, want.overflow_irq);
         $display("   got div=%0d cnt=%0d irq=%0b",
                  got.divider_value, got.counter_value, got.overflow_irq);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      string   bad;
      if (reset) begin
         reload_q       = '0;
         control_q      = '0;
         divider_q      = '0;
         counter_q      = '0;
         div_prescale_q = '0;
         cnt_prescale_q = '0;
         expected_readings.delete();
         beats_in  <= 0;
         beats_out <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_addr)
               CSR_RELOAD:  reload_q  = csr_wdata[VALUE_W-1:0];
               CSR_CONTROL: control_q = csr_wdata[CONTROL_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            expected_readings.push_back(advance_timer(req_data));
            beats_in <= beats_in + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            beats_out <= beats_out + 1;
            if (expected_readings.size() == 0) begin
               report("result with nothing pending", '0, rsp_data);
            end else begin
               want = expected_readings.pop_front();
               bad  = "";
               if (rsp_data.divider_value !== want.divider_value) bad = {bad, " divider_value"};
               if (rsp_data.counter_value !== want.counter_value) bad = {bad, " counter_value"};
               if (rsp_data.overflow_irq !== want.overflow_irq)   bad = {bad, " overflow_irq"};
               if (bad != "") report(bad, want, rsp_data);
            end
         end
      end
   end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

   import divrt_pkg::*;

   localparam int DIV_PERIOD    = 512;
   // two register stages inside the block; a few spare cycles before touching registers
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_CYCLES   = 60;
   localparam int CYCLE_LIMIT   = 700000;
   localparam int WRAP_CAP      = 30;

   localparam logic [CONTROL_W-1:0] TIMER_ON = CONTROL_W'(1 << CTRL_ENABLE_BIT);

   logic                   clock;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // handshake between the sender and the receiver for the one long hold-off
   logic hold_req = 1'b0;

   int pending;
   int mismatches;
   int overflows;
   int divider_wraps;

   int cycles     = 0;
   int beats_sent = 0;
   int clears     = 0;
   int settings   = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   divider_and_reloading_timer_top #(
      .DIVIDER_PERIOD (DIV_PERIOD)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   timer_result_checker #(
      .DIVIDER_PERIOD (DIV_PERIOD)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_wr_en     (csr_wr_en),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .pending       (pending),
      .mismatches    (mismatches),
      .overflows     (overflows),
      .divider_wraps (divider_wraps)
   );

   // Watchdog: count cycles, declare failure if the run never drains.
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("tb_top: errors");
      $finish;
   end

   // Receiver: alternate free and stalled stretches. Most stalls are short, a few
   // long, and now and then a long stretch runs with no stall at all. Serve the
   // single long hold-off once the sender asks for it, so the block backs up.
   initial begin
      int span;
      int roll;
      bit held;
      held = 1'b0;
      forever begin
         if (hold_req && !held) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            roll = $urandom_range(0, 99);
            span = (roll < 8) ? $urandom_range(40, 120) : $urandom_range(1, 6);
            rsp_stall <= 1'b0;
            repeat (span) @(posedge clock);
            roll = $urandom_range(0, 99);
            if (roll < 60)      span = 1;
            else if (roll < 90) span = $urandom_range(2, 6);
            else if (roll < 97) span = $urandom_range(7, 15);
            else                span = $urandom_range(20, 40);
            rsp_stall <= 1'b1;
            repeat (span) @(posedge clock);
         end
      end
   end

   // Sender gap: mostly none or short, rarely long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic req_type make_beat(input int ticks, input bit clr);
      req_type b;
      b.elapsed_ticks = ticks[TICKS_W-1:0];
      b.clear_divider = clr;
      return b;
   endfunction

   // Mostly ticks inside the nominal 0..32 range, the rest up to the 6-bit top.
   function automatic req_type random_beat(input int clear_pct);
      req_type b;
      int      roll;
      roll = $urandom_range(0, 99);
      b.elapsed_ticks = TICKS_W'((roll < 80) ? $urandom_range(0, 32) : $urandom_range(33, 63));
      b.clear_divider = ($urandom_range(0, 99) < clear_pct);
      return b;
   endfunction

   // Offer one beat after an optional gap; hold it until the block takes it.
   // Valid stays high on return so back-to-back beats need no extra edge.
   task automatic send_beat(input req_type beat, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_data  <= req_type'(7'($urandom_range(0, 127)));
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
      beats_sent++;
      if (beat.clear_divider) clears++;
   endtask

   // Drop valid and wait until every expected reading is back, plus the pipe depth.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both registers on consecutive edges; junk in the unused control bits.
   task automatic program_timer(input logic [VALUE_W-1:0] reload,
                                input logic [CONTROL_W-1:0] ctrl);
      logic [CSR_DATA_W-1:0] word;
      word                 = CSR_DATA_W'($urandom_range(0, 255));
      word[CONTROL_W-1:0]  = ctrl;
      csr_wr_en <= 1'b1;
      csr_addr  <= CSR_RELOAD;
      csr_wdata <= reload;
      @(posedge clock);
      csr_addr  <= CSR_CONTROL;
      csr_wdata <= word;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings++;
   endtask

   initial begin
      logic [VALUE_W-1:0]   rl;
      logic [CONTROL_W-1:0] ct;
      int                   n;
      int                   ph;
      int                   i;
      int                   gap;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Registers at reset: counter off, only the divider runs. Hit zero, top
      // and mid tick counts, and two clears.
      send_beat(make_beat(0, 1'b0), 0);
      send_beat(make_beat(63, 1'b0), 0);
      send_beat(make_beat(63, 1'b0), 2);
      send_beat(make_beat(63, 1'b1), 0);
      send_beat(make_beat(32, 1'b0), 0);
      send_beat(make_beat(1, 1'b1), 1);
      send_beat(make_beat(0, 1'b0), 0);

      // Fastest rate: large tick counts still give one advance per beat, the
      // surplus carries; exact period and one short of it.
      settle();
      program_timer(8'hFF, TIMER_ON | RATE_16);
      send_beat(make_beat(63, 1'b0), 0);
      send_beat(make_beat(63, 1'b0), 0);
      send_beat(make_beat(16, 1'b0), 0);
      send_beat(make_beat(15, 1'b0), 3);
      send_beat(make_beat(1, 1'b0), 0);
      send_beat(make_beat(0, 1'b0), 0);
      send_beat(make_beat(32, 1'b1), 0);

      settle();
      program_timer(8'h00, TIMER_ON | RATE_64);
      send_beat(make_beat(63, 1'b0), 0);
      send_beat(make_beat(1, 1'b0), 0);
      send_beat(make_beat(63, 1'b0), 0);

      settle();
      program_timer(8'h5A, TIMER_ON | RATE_256);
      send_beat(make_beat(63, 1'b0), 0);
      send_beat(make_beat(63, 1'b0), 0);

      settle();
      program_timer(8'h00, TIMER_ON | RATE_1024);
      send_beat(make_beat(63, 1'b0), 0);
      send_beat(make_beat(0, 1'b1), 0);

      // Random phases, one timer setting each. The first runs the counter up to
      // overflow and then cycles it from a high reload; the second reloads at the
      // top so every advance overflows.
      for (ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin rl = 8'hF0; ct = TIMER_ON | RATE_16; n = 300; end
            1: begin rl = 8'hFF; ct = TIMER_ON | RATE_16; n = 120; end
            2: begin rl = 8'h00; ct = TIMER_ON | RATE_64; n = 100; end
            3: begin
               rl = VALUE_W'($urandom_range(0, 255));
               ct = TIMER_ON | RATE_256;
               n  = 100;
            end
            4: begin
               rl = VALUE_W'($urandom_range(0, 255));
               ct = CONTROL_W'($urandom_range(0, 3));
               n  = 80;
            end
            5: begin rl = 8'h80; ct = TIMER_ON | RATE_1024; n = 100; end
            6: begin
               rl = VALUE_W'($urandom_range(0, 255));
               ct = TIMER_ON | CONTROL_W'($urandom_range(0, 3));
               n  = 100;
            end
            default: begin
               rl = VALUE_W'($urandom_range(0, 255));
               ct = CONTROL_W'($urandom_range(0, 7));
               n  = 100;
            end
         endcase
         settle();
         program_timer(rl, ct);
         for (i = 0; i < n; i++) begin
            // ask for the long receiver hold-off and keep offering beats meanwhile
            if (ph == 1 && i == 0) hold_req <= 1'b1;
            // pause the sender once mid-phase until the block has fully drained
            if (ph == 2 && i == n / 2) settle();
            gap = ((ph == 1 && i < 90) || (ph == 6 && i < 40)) ? 0 : pick_gap();
            send_beat(random_beat(6), gap);
         end
      end

      // Short run of near-top tick counts without clears at the fastest rate:
      // one advance per beat with the surplus carrying over.
      settle();
      program_timer(VALUE_W'($urandom_range(0, 255)), TIMER_ON | RATE_16);
      n = 0;
      while (divider_wraps == 0 && n < WRAP_CAP) begin
         send_beat(make_beat($urandom_range(48, 63), 1'b0), 0);
         n++;
      end

      settle();
      $display("run covered %0d beats over %0d timer settings (all rates, on and off),",
               beats_sent, settings);
      $display("%0d clears, %0d counter overflows, %0d divider wraps, %0d mismatches",
               clears, overflows, divider_wraps, mismatches);
      if (mismatches == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/divrt_pkg.sv
design/divrt_accum.sv
design/divider_and_reloading_timer_top.sv
dv/timer_result_checker.sv
dv/tb_top.sv
